// File: rtl/iwrs_pkg.sv
// Shared types and fixed field widths of the inverse-weight roulette selector.
// No dependencies; the interfaces, controller, datapath and top level use it.
`timescale 1ns / 1ps
`default_nettype none

package iwrs_pkg;

    // Fixed widths of the stream fields.
    localparam int H_W    = 16;
    localparam int RAND_W = 32;
    localparam int IDX_W  = 6;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_DECIDE,
        ST_MOD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DRAW,
        ST_WALK,
        ST_RESULT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // capture the input beat, start the reciprocal
        logic div_step;    // one restoring step of the reciprocal
        logic store;       // write the weight, add it to the sum, bump the count
        logic mod_start;   // start random_word modulo count
        logic mod_step;    // one restoring step of the modulo
        logic mul_lo;      // random word times low half of the sum
        logic mul_hi;      // random word times high half of the sum
        logic walk_start;  // form the draw, read entry zero
        logic walk_step;   // accumulate one weight and compare
        logic out_load;    // fill the result register
        logic clear;       // drop list state for the next list
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic room;        // list not full yet
        logic last;        // captured beat closes the list
        logic div_last;    // reciprocal finishes on this step
        logic mod_last;    // modulo finishes on this step
        logic walk_hit;    // the walk has found the pick
    } t_status;

endpackage

`default_nettype wire

// File: rtl/iwrs_if.sv
// Valid/ready stream interfaces for the selector's input and result channels.
// Depends on iwrs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface iwrs_in_if;
    logic                       valid;
    logic                       ready;
    logic [iwrs_pkg::H_W-1:0]   h_value;
    logic                       is_last;
    logic [iwrs_pkg::RAND_W-1:0] random_word;

    modport source (output valid, output h_value, output is_last, output random_word,
                    input ready);
    modport sink   (input valid, input h_value, input is_last, input random_word,
                    output ready);
endinterface

interface iwrs_out_if;
    logic                       valid;
    logic                       ready;
    logic [iwrs_pkg::IDX_W-1:0] chosen_index;
    logic                       zero_seen;
    logic                       overflowed;

    modport source (output valid, output chosen_index, output zero_seen, output overflowed,
                    input ready);
    modport sink   (input valid, input chosen_index, input zero_seen, input overflowed,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/iwrs_ctrl.sv
// Sequencer of the selector: handshakes, mode register and step commands.
// Depends on iwrs_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module iwrs_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_wdata,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  iwrs_pkg::t_status i_status,
    output iwrs_pkg::t_cmd    o_cmd
);

    iwrs_pkg::t_state r_state, n_state;
    logic             r_uniform;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iwrs_pkg::ST_IDLE;
            r_uniform   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_uniform <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            iwrs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.room ? iwrs_pkg::ST_DIV : iwrs_pkg::ST_DECIDE;
                end
            end
            iwrs_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = iwrs_pkg::ST_STORE;
                end
            end
            iwrs_pkg::ST_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = iwrs_pkg::ST_DECIDE;
            end
            iwrs_pkg::ST_DECIDE: begin
                if (!i_status.last) begin
                    n_state = iwrs_pkg::ST_IDLE;
                end else if (r_uniform) begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = iwrs_pkg::ST_MOD;
                end else begin
                    n_state = iwrs_pkg::ST_MUL_LO;
                end
            end
            iwrs_pkg::ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) begin
                    n_state = iwrs_pkg::ST_RESULT;
                end
            end
            iwrs_pkg::ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = iwrs_pkg::ST_MUL_HI;
            end
            iwrs_pkg::ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = iwrs_pkg::ST_DRAW;
            end
            iwrs_pkg::ST_DRAW: begin
                o_cmd.walk_start = 1'b1;
                n_state          = iwrs_pkg::ST_WALK;
            end
            iwrs_pkg::ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_hit) begin
                    n_state = iwrs_pkg::ST_RESULT;
                end
            end
            iwrs_pkg::ST_RESULT: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = iwrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iwrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/iwrs_datapath.sv
// Datapath of the selector: reciprocal divider, weight memory, sum, modulo unit,
// draw multiplier, prefix walk and result register. Depends on iwrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iwrs_datapath #(
    parameter int MAX_CHOICES         = 64,
    parameter int RECIP_FRACTION_BITS = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  iwrs_pkg::t_cmd                i_cmd,
    output iwrs_pkg::t_status             o_status,
    input  wire [iwrs_pkg::H_W-1:0]       i_h_value,
    input  wire                           i_is_last,
    input  wire [iwrs_pkg::RAND_W-1:0]    i_random_word,
    output logic [iwrs_pkg::IDX_W-1:0]    o_chosen_index,
    output logic                          o_zero_seen,
    output logic                          o_overflowed
);

    localparam int H_W       = iwrs_pkg::H_W;
    localparam int RAND_W    = iwrs_pkg::RAND_W;
    localparam int CNT_W     = $clog2(MAX_CHOICES + 1);
    localparam int ADDR_W    = $clog2(MAX_CHOICES);
    localparam int W_W       = RECIP_FRACTION_BITS + 1;
    localparam int SUM_W     = W_W + ADDR_W;
    localparam int STEPS_MAX = (W_W > RAND_W) ? W_W : RAND_W;
    localparam int STEP_W    = $clog2(STEPS_MAX);

    // list state
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic              r_zero;
    logic              r_over;

    // captured beat
    logic [H_W-1:0]    r_dvsr;
    logic              r_last;
    logic [RAND_W-1:0] r_rand;

    // shared step counter
    logic [STEP_W-1:0] r_step;

    // reciprocal divider
    logic [H_W-1:0]    r_drem;
    logic [W_W-1:0]    r_quo;
    logic [H_W:0]      div_trial;
    logic              div_ge;
    logic [H_W-1:0]    drem_next;

    // modulo unit
    logic [CNT_W-1:0]  r_mrem;
    logic [RAND_W-1:0] r_mshift;
    logic [CNT_W:0]    mod_trial;
    logic              mod_ge;
    logic [CNT_W-1:0]  mrem_next;

    // draw multiplier
    logic [63:0]       sum_ext;
    logic [31:0]       mul_b;
    logic [63:0]       prod;
    logic [63:0]       r_prod_lo;
    logic [63:0]       r_prod_hi;
    logic [SUM_W-1:0]  r_draw;

    // weight memory and walk
    logic [W_W-1:0]    weight_store [MAX_CHOICES];
    logic [W_W-1:0]    r_rdata;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] r_wptr;
    logic [ADDR_W-1:0] r_widx;
    logic [SUM_W-1:0]  r_run;
    logic [SUM_W-1:0]  run_next;
    logic              walk_hit;

    // result
    logic [ADDR_W-1:0]          r_pick;
    logic [iwrs_pkg::IDX_W-1:0] r_out_idx;
    logic                       r_out_zero;
    logic                       r_out_over;

    // dividend is 2^RECIP_FRACTION_BITS: a one on the first step, zeros after
    assign div_trial = {r_drem, (r_step == '0)};
    assign div_ge    = div_trial >= {1'b0, r_dvsr};
    assign drem_next = div_ge ? H_W'(div_trial - {1'b0, r_dvsr}) : H_W'(div_trial);

    assign mod_trial = {r_mrem, r_mshift[RAND_W-1]};
    assign mod_ge    = mod_trial >= {1'b0, r_count};
    assign mrem_next = mod_ge ? CNT_W'(mod_trial - {1'b0, r_count}) : CNT_W'(mod_trial);

    assign sum_ext = 64'(r_sum);
    assign mul_b   = i_cmd.mul_hi ? sum_ext[63:32] : sum_ext[31:0];
    assign prod    = 64'(r_rand) * 64'(mul_b);

    assign rd_addr  = i_cmd.walk_start ? '0 : r_wptr;
    assign run_next = r_run + SUM_W'(r_rdata);
    // past the end clamps to the last stored entry
    assign walk_hit = (run_next > r_draw) ||
                      (CNT_W'(r_widx) == CNT_W'(r_count - CNT_W'(1)));

    // control-like list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_zero  <= 1'b0;
            r_over  <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_sum   <= '0;
            r_zero  <= 1'b0;
            r_over  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_h_value == '0) begin
                    r_zero <= 1'b1;
                end
                if (r_count == CNT_W'(MAX_CHOICES)) begin
                    r_over <= 1'b1;
                end
            end
            if (i_cmd.store) begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + SUM_W'(r_quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvsr <= (i_h_value == '0) ? H_W'(1) : i_h_value;
            r_last <= i_is_last;
            r_rand <= i_random_word;
            r_drem <= '0;
            r_quo  <= '0;
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            r_drem <= drem_next;
            r_quo  <= {r_quo[W_W-2:0], div_ge};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.mod_start) begin
            r_mrem   <= '0;
            r_mshift <= r_rand;
            r_step   <= '0;
        end
        if (i_cmd.mod_step) begin
            r_mrem   <= mrem_next;
            r_mshift <= {r_mshift[RAND_W-2:0], 1'b0};
            r_step   <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(RAND_W - 1)) begin
                r_pick <= ADDR_W'(mrem_next);
            end
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= prod;
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= prod;
        end
        if (i_cmd.walk_start) begin
            r_draw <= SUM_W'(r_prod_hi) + SUM_W'(r_prod_lo[63:32]);
            r_run  <= '0;
            r_widx <= '0;
            r_wptr <= ADDR_W'(1);
        end
        if (i_cmd.walk_step) begin
            r_run  <= run_next;
            r_widx <= r_wptr;
            r_wptr <= r_wptr + ADDR_W'(1);
            if (walk_hit) begin
                r_pick <= r_widx;
            end
        end
        if (i_cmd.out_load) begin
            r_out_idx  <= iwrs_pkg::IDX_W'(r_pick);
            r_out_zero <= r_zero;
            r_out_over <= r_over;
        end
    end

    // weight memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            weight_store[r_count[ADDR_W-1:0]] <= r_quo;
        end
        r_rdata <= weight_store[rd_addr];
    end

    always_comb begin
        o_status.room     = (r_count != CNT_W'(MAX_CHOICES));
        o_status.last     = r_last;
        o_status.div_last = (r_step == STEP_W'(W_W - 1));
        o_status.mod_last = (r_step == STEP_W'(RAND_W - 1));
        o_status.walk_hit = walk_hit;
    end

    assign o_chosen_index = r_out_idx;
    assign o_zero_seen    = r_out_zero;
    assign o_overflowed   = r_out_over;

endmodule

`default_nettype wire

// File: rtl/inverse_weight_roulette_select_core.sv
// Inverse-weight roulette selector, top level: controller plus datapath.
// Depends on iwrs_pkg, iwrs_if, iwrs_ctrl and iwrs_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one heuristic value per input beat and turns it into a weight
// floor(2^RECIP_FRACTION_BITS / h) with a bit-serial restoring divider, one
// quotient bit per cycle. A value of zero counts as one and sets zero_seen;
// values past MAX_CHOICES are dropped and set overflowed. The beat marked
// is_last closes the list and yields one result beat. In uniform mode
// (configuration bit set) the pick is random_word modulo the stored count,
// found in 32 restoring steps. Otherwise the draw (random_word * weight sum)
// >> 32 is formed from two 32x32 partial products, and the stored weights are
// walked from index zero, one per cycle out of the weight memory, until the
// running sum exceeds the draw (clamped to the last stored entry). One item
// at a time: an accepted beat holds ready low while the divider runs and the
// weight is stored (a dropped value skips both); a last beat holds it further
// through the modulo steps or the products, draw and walk, until the pick is
// loaded. The result sits in an output register, so a new list is accepted
// while the previous pick waits; the list state clears as the pick is loaded
// there. The user must write the mode bit only while the block is idle; the
// block itself does not enforce this.
module inverse_weight_roulette_select_core #(
    parameter int MAX_CHOICES         = 64,
    parameter int RECIP_FRACTION_BITS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_wdata,
    iwrs_in_if.sink      i_in,
    iwrs_out_if.source   o_out
);

    iwrs_pkg::t_cmd    cmd;
    iwrs_pkg::t_status status;
    logic              in_ready;
    logic              out_valid;

    iwrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    iwrs_datapath #(
        .MAX_CHOICES         (MAX_CHOICES),
        .RECIP_FRACTION_BITS (RECIP_FRACTION_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_h_value      (i_in.h_value),
        .i_is_last      (i_in.is_last),
        .i_random_word  (i_in.random_word),
        .o_chosen_index (o_out.chosen_index),
        .o_zero_seen    (o_out.zero_seen),
        .o_overflowed   (o_out.overflowed)
    );

    // drive the handshake side of both channels
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

// File: verif/iwrs_pick_checker.sv
// Checker for the inverse-weight roulette selector: watches the choice,
// pick and mode-write ports, predicts every pick and compares it field by field.
// Depends on iwrs_pkg and the stream interfaces in iwrs_if.
`timescale 1ns / 1ps
`default_nettype none

module iwrs_pick_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_cfg_we,
    input  wire   i_cfg_wdata,
    iwrs_in_if    i_choice,
    iwrs_out_if   i_pick,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_picks_seen
);

    localparam int H_W         = iwrs_pkg::H_W;
    localparam int RAND_W      = iwrs_pkg::RAND_W;
    localparam int IDX_W       = iwrs_pkg::IDX_W;
    localparam int MAX_CHOICES = 64;
    localparam int FRAC_BITS   = 32;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic             zero_seen;
        logic             overflowed;
    } t_pick;

    logic [32:0] weight_mem [MAX_CHOICES];
    logic [6:0]  list_len;
    logic [38:0] weight_total;
    logic        zero_hit;
    logic        overflow_hit;
    logic        uniform_sel;
    t_pick       pick_queue [$];
    int          fails = 0;
    int          picks = 0;

    function automatic logic [IDX_W-1:0] roulette_index(input logic [31:0] rnd);
        logic [70:0] prod;
        logic [38:0] draw;
        logic [38:0] run;
        logic [6:0]  sel;
        logic        found;
        prod  = 71'(rnd) * 71'(weight_total);
        draw  = prod[70:32];
        run   = '0;
        sel   = list_len - 7'd1;
        found = 1'b0;
        for (int i = 0; i < MAX_CHOICES; i++) begin
            if (!found && i < list_len) begin
                run = run + 39'(weight_mem[i]);
                if (run > draw) begin
                    sel   = 7'(i);
                    found = 1'b1;
                end
            end
        end
        return sel[IDX_W-1:0];
    endfunction

    task automatic clear_list();
        list_len     = '0;
        weight_total = '0;
        zero_hit     = 1'b0;
        overflow_hit = 1'b0;
    endtask

    // Fold one choice into the list; a closing choice queues the pick it must produce.
    task automatic absorb_choice(input logic [H_W-1:0] h, input logic last,
                                 input logic [RAND_W-1:0] rnd);
        logic [16:0] hv;
        logic [32:0] w;
        t_pick       p;
        hv = {1'b0, h};
        if (h == '0) begin
            hv       = 17'd1;
            zero_hit = 1'b1;
        end
        if (list_len < MAX_CHOICES) begin
            w = 33'((64'd1 << FRAC_BITS) / 64'(hv));
            weight_mem[list_len[5:0]] = w;
            weight_total = weight_total + 39'(w);
            list_len     = list_len + 7'd1;
        end else begin
            overflow_hit = 1'b1;
        end
        if (last) begin
            p.chosen_index = uniform_sel ? IDX_W'(rnd % list_len) : roulette_index(rnd);
            p.zero_seen    = zero_hit;
            p.overflowed   = overflow_hit;
            pick_queue.push_back(p);
            clear_list();
        end
    endtask

    always @(posedge i_clk) begin
        t_pick want;
        if (!i_rst_n) begin
            clear_list();
            uniform_sel = 1'b0;
            pick_queue.delete();
        end else begin
            if (i_cfg_we)
                uniform_sel = i_cfg_wdata;
            if (i_pick.valid && i_pick.ready) begin
                if (pick_queue.size() == 0) begin
                    $display("%0t: pick beat with none expected: index %0d zero %0b ovf %0b",
                             $time, i_pick.chosen_index, i_pick.zero_seen, i_pick.overflowed);
                    fails++;
                end else begin
                    want = pick_queue.pop_front();
                    picks++;
                    if (i_pick.chosen_index !== want.chosen_index) begin
                        $display("%0t: chosen_index expected %0d got %0d",
                                 $time, want.chosen_index, i_pick.chosen_index);
                        fails++;
                    end
                    if (i_pick.zero_seen !== want.zero_seen) begin
                        $display("%0t: zero_seen expected %0b got %0b",
                                 $time, want.zero_seen, i_pick.zero_seen);
                        fails++;
                    end
                    if (i_pick.overflowed !== want.overflowed) begin
                        $display("%0t: overflowed expected %0b got %0b",
                                 $time, want.overflowed, i_pick.overflowed);
                        fails++;
                    end
                end
            end
            if (i_choice.valid && i_choice.ready)
                absorb_choice(i_choice.h_value, i_choice.is_last, i_choice.random_word);
        end
        o_fail_count <= fails;
        o_pending    <= pick_queue.size();
        o_picks_seen <= picks;
    end

endmodule

`default_nettype wire

// File: verif/tb_inverse_weight_roulette_select_core.sv
// Top of the selector regression: clock, reset, choice and mode stimulus,
// random stalls on the pick channel, and the final verdict.
// Depends on iwrs_pkg, iwrs_if, the selector core and iwrs_pick_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_inverse_weight_roulette_select_core;

    localparam int H_W    = iwrs_pkg::H_W;
    localparam int RAND_W = iwrs_pkg::RAND_W;

    // Leave margin for the last choice and its closing beat to finish in the
    // block before touching the mode bit or ending.
    localparam int SETTLE_CYCLES = 150;
    // Cycle limit for the whole run, kept well above the slowest legal run.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 140;
    localparam int PHASES        = 8;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    int fail_count;
    int pending;
    int picks_seen;
    int cycles = 0;

    int items_sent     = 0;
    int lists_sent     = 0;
    int uniform_lists  = 0;
    int overflow_lists = 0;
    logic mode_now     = 1'b0;
    bit in_quiet       = 1'b0;
    bit out_quiet      = 1'b0;

    iwrs_in_if  choice_if ();
    iwrs_out_if pick_if ();

    inverse_weight_roulette_select_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (choice_if),
        .o_out       (pick_if)
    );

    iwrs_pick_checker checker_u (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_choice     (choice_if),
        .i_pick       (pick_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_picks_seen (picks_seen)
    );

    // 20 ns period: 10 ns high, 10 ns low.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d picks still outstanding", cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Pick-channel receiver: before each beat hold ready low for a random stall
    // (none while out_quiet is set), then wait for the beat.
    // Ready is touched at most once per edge, so a zero stall keeps it high.
    initial begin
        int stall;
        pick_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = out_quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                pick_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pick_if.ready <= 1'b1;
            do @(posedge clk); while (!(pick_if.valid && pick_if.ready));
        end
    end

    // Drive one choice beat after a random gap, then hold it until accepted.
    // Back-to-back beats keep valid high without dropping it in between.
    task automatic send_choice(input logic [H_W-1:0] h, input logic last,
                               input logic [RAND_W-1:0] rnd);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            choice_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        choice_if.valid       <= 1'b1;
        choice_if.h_value     <= h;
        choice_if.is_last     <= last;
        choice_if.random_word <= rnd;
        do @(posedge clk); while (!(choice_if.valid && choice_if.ready));
        items_sent++;
        if (last) begin
            lists_sent++;
            if (mode_now)
                uniform_lists++;
        end
    endtask

    // Heuristic values: zeros, tiny values (heavy weights), values near the
    // top (light weights), and the full range for everything else.
    function automatic logic [H_W-1:0] random_h();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return H_W'($urandom_range(1, 4));
            3:       return H_W'(16'hFFFF - $urandom_range(0, 3));
            default: return H_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAND_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return RAND_W'($urandom);
        endcase
    endfunction

    // Mostly short lists so picks come often; some long ones to fill the
    // store, and a few that run past capacity so extras get dropped.
    function automatic int random_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return $urandom_range(1, 6);
        else if (sel < 96)
            return $urandom_range(7, 64);
        else
            return $urandom_range(65, 70);
    endfunction

    task automatic send_random_list(input int len);
        for (int i = 0; i < len; i++)
            send_choice(random_h(), i == len - 1, random_word());
        if (len > 64)
            overflow_lists++;
    endtask

    // Drop valid and wait until every queued pick has been taken. The first
    // edge lets the checker count a closing beat accepted on this very edge.
    task automatic drain_picks();
        choice_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Mode writes only happen with the block idle: drain, settle, then write.
    task automatic write_mode(input logic m);
        drain_picks();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_now  = m;
    endtask

    initial begin
        int phase_start;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= 1'b0;
        choice_if.valid       <= 1'b0;
        choice_if.h_value     <= '0;
        choice_if.is_last     <= 1'b0;
        choice_if.random_word <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Roulette mode out of reset.
        // Zero, unit and largest values; a zero draw must land on index 0.
        send_choice(16'd0,     1'b0, 32'hDEAD_BEEF);
        send_choice(16'd1,     1'b0, 32'h1234_5678);
        send_choice(16'hFFFF,  1'b0, 32'h0);
        send_choice(16'd2,     1'b1, 32'h0);
        // One-entry list with the largest draw.
        send_choice(16'hFFFF,  1'b1, 32'hFFFF_FFFF);
        // Largest draw with a heavy weight in front of light ones: pick lands near the end.
        send_choice(16'd1,     1'b0, 32'hFFFF_FFFF);
        send_choice(16'hFFFF,  1'b0, 32'hFFFF_FFFF);
        send_choice(16'hFFFF,  1'b0, 32'hFFFF_FFFF);
        send_choice(16'd3,     1'b1, 32'hFFFF_FFFF);
        // Lone zero value, flagged and weighted as one.
        send_choice(16'd0,     1'b1, 32'h8000_0000);
        // Running sum equal to the draw does not pick: must move to index 1.
        send_choice(16'd1,     1'b0, 32'h0);
        send_choice(16'd1,     1'b1, 32'h8000_0000);

        // Uniform mode: the pick is the random word modulo the list length.
        write_mode(1'b1);
        send_choice(16'd7,     1'b0, 32'h0);
        send_choice(16'd0,     1'b0, 32'h0);
        send_choice(16'd9,     1'b0, 32'h0);
        send_choice(16'hFFFF,  1'b0, 32'h0);
        send_choice(16'd1,     1'b1, 32'hFFFF_FFFF);
        send_choice(16'd3,     1'b0, 32'h0);
        send_choice(16'd3,     1'b0, 32'h0);
        send_choice(16'd3,     1'b1, 32'd5);
        send_choice(16'd1,     1'b1, random_word());

        // Random phases: force both modes first, then let the seed choose.
        // Some phases run with no gaps on one side or both.
        for (int p = 0; p < PHASES; p++) begin
            write_mode(p == 0 ? 1'b0 : p == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            in_quiet   = (p == 3) || (p == 6);
            out_quiet <= (p == 4) || (p == 6);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_list(random_len());
        end

        drain_picks();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d choices in %0d lists (%0d uniform, %0d past capacity)",
                 items_sent, lists_sent, uniform_lists, overflow_lists);
        $display("checked %0d picks, %0d mismatches", picks_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/iwrs_pkg.sv
rtl/iwrs_if.sv
rtl/iwrs_ctrl.sv
rtl/iwrs_datapath.sv
rtl/inverse_weight_roulette_select_core.sv
verif/iwrs_pick_checker.sv
verif/tb_inverse_weight_roulette_select_core.sv
